@@ src/pdbu_pkg.sv @@
// Package for the particle domain boundary unit.
// Holds the input and result word types, register indexes, mode codes and ALU ops.
// No dependencies.
package pdbu_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int DIV_STEPS = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_END = 2'd2;

	// boundary rules
	localparam logic [1:0] MODE_EXIT = 2'd0;
	localparam logic [1:0] MODE_WRAP = 2'd1;
	localparam logic [1:0] MODE_REFLECT = 2'd2;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic signed [31:0] in_pos;
		logic signed [31:0] in_vel;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] out_pos;
		logic signed [31:0] out_vel;
		logic active;
	} out_word_t;

endpackage

@@ src/pdbu_alu.sv @@
// Shared add/subtract unit of the particle domain boundary unit.
// Depends on pdbu_pkg (alu_op_t).
module pdbu_alu import pdbu_pkg::*; #(
	parameter int W = 46
) (
	input logic signed [W-1:0] a,
	input logic signed [W-1:0] b,
	input alu_op_t op,
	output logic signed [W-1:0] y
);

	always_comb begin
		if (op == ALU_SUB) begin
			y = a - b;
		end else begin
			y = a + b;
		end
	end

endmodule

@@ src/particle_domain_boundary_unit.sv @@
// Top level of the particle domain boundary unit: sequencer, registers, config port.
// Depends on pdbu_pkg and pdbu_alu.
//
// Applies one boundary rule (exit, periodic wrap, reflect) to a signed Q16.16
// particle coordinate and its velocity. A word is accepted on a clock edge with
// start high and busy low; busy then stays high until the result is ready. The
// result word is shown on result for exactly one cycle with done high; there is
// no back-pressure, so the receiver must take it in that cycle. A new start may
// be given in the same cycle that done is high. Exit mode, unused mode, and
// periodic mode with the point inside or an empty or inverted domain go from
// check straight to finish; periodic mode with the point outside adds a prep
// step, a 32-step restoring remainder loop and two fix-up steps; reflect mode
// with n mirrors, n at most MAX_REFLECT, adds one reflect step per mirror plus
// a last step that finds the point inside or the count at its limit. All of
// it runs through a single add/subtract unit stepped by the sequencer, one
// operation per cycle.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once and
// must be issued only while busy is low and no done is pending. Writes to an
// unused index are ignored. There is no reset sweep; the block is ready right
// after reset.
module particle_domain_boundary_unit import pdbu_pkg::*; #(
	parameter int MAX_REFLECT = 100
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_wdata,
	input logic start,
	input in_word_t item,
	output logic busy,
	output logic done,
	output out_word_t result
);

	// reflect counter and working width: each mirror can move the point by
	// about 2^33, so the position grows by one bit per doubling of the count
	localparam int CNT_W = $clog2(MAX_REFLECT + 1);
	localparam int PW = 32 + 3 + CNT_W;
	localparam int DCNT_W = $clog2(DIV_STEPS);

	localparam logic signed [PW-1:0] SAT_HI = {{(PW-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [PW-1:0] SAT_LO = {{(PW-31){1'b1}}, {31{1'b0}}};

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_CHECK = 8'b0000_0010,
		ST_PREP  = 8'b0000_0100,
		ST_DIV   = 8'b0000_1000,
		ST_FIX1  = 8'b0001_0000,
		ST_FIX2  = 8'b0010_0000,
		ST_REFL  = 8'b0100_0000,
		ST_FIN   = 8'b1000_0000
	} state_t;

	state_t state_q;

	// config registers
	logic [1:0] bc_mode_q;
	logic signed [31:0] domain_start_q;
	logic signed [31:0] domain_end_q;

	// control flags and counters
	logic act_q;
	logic flip_q;
	logic side_q;		// 1: point below start (wrap mode)
	logic done_q;
	logic [CNT_W-1:0] refl_cnt_q;
	logic [DCNT_W-1:0] div_cnt_q;

	// datapath
	logic signed [PW-1:0] pos_q;
	logic signed [31:0] vel_q;
	logic [31:0] size_q;
	logic [31:0] rem_q;
	logic [31:0] div_q;
	out_word_t result_q;

	logic accept;
	logic signed [PW-1:0] s_w;
	logic signed [PW-1:0] e_w;
	logic signed [PW-1:0] vel_w;
	logic signed [PW-1:0] bnd_w;
	logic below_s;
	logic above_e;
	logic exit_out;
	logic refl_go;
	logic size_bad;

	logic signed [PW-1:0] alu_a;
	logic signed [PW-1:0] alu_b;
	logic signed [PW-1:0] alu_y;
	alu_op_t alu_op;

	logic [31:0] pos_sat;
	logic [31:0] vel_neg_sat;

	assign accept = start && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign result = result_q;

	assign s_w = {{(PW-32){domain_start_q[31]}}, domain_start_q};
	assign e_w = {{(PW-32){domain_end_q[31]}}, domain_end_q};
	assign vel_w = {{(PW-32){vel_q[31]}}, vel_q};

	assign below_s = (pos_q < s_w);
	assign above_e = (pos_q > e_w);
	assign exit_out = (pos_q <= s_w) || (pos_q >= e_w);
	// above-end test wins, also for inverted bounds
	assign bnd_w = above_e ? e_w : s_w;
	assign refl_go = (below_s || above_e) && (refl_cnt_q != CNT_W'(MAX_REFLECT));
	// domain length not positive: wrap passes the point through
	assign size_bad = alu_y[PW-1] || (alu_y == '0);

	always_comb begin
		alu_a = '0;
		alu_b = '0;
		alu_op = ALU_SUB;
		unique case (state_q)
			ST_CHECK: begin
				alu_a = e_w;
				alu_b = s_w;
			end
			ST_PREP: begin
				if (side_q) begin
					alu_a = s_w;
					alu_b = pos_q;
				end else begin
					alu_a = pos_q;
					alu_b = e_w;
				end
			end
			ST_DIV: begin
				// trial subtract of one restoring remainder step
				alu_a = {{(PW-33){1'b0}}, rem_q, div_q[31]};
				alu_b = {{(PW-32){1'b0}}, size_q};
			end
			ST_FIX1: begin
				alu_a = {{(PW-32){1'b0}}, size_q};
				alu_b = {{(PW-32){1'b0}}, rem_q};
			end
			ST_FIX2: begin
				alu_b = {{(PW-32){1'b0}}, rem_q};
				if (side_q) begin
					alu_a = s_w;
					alu_op = ALU_ADD;
				end else begin
					alu_a = e_w;
				end
			end
			ST_REFL: begin
				alu_a = {bnd_w[PW-2:0], 1'b0};
				alu_b = pos_q;
			end
			ST_FIN: begin
				alu_b = vel_w;
			end
			default: begin
				alu_op = ALU_SUB;
			end
		endcase
	end

	pdbu_alu #(
		.W(PW)
	) u_alu (
		.a(alu_a),
		.b(alu_b),
		.op(alu_op),
		.y(alu_y)
	);

	always_comb begin
		if (pos_q > SAT_HI) begin
			pos_sat = SAT_HI[31:0];
		end else if (pos_q < SAT_LO) begin
			pos_sat = SAT_LO[31:0];
		end else begin
			pos_sat = pos_q[31:0];
		end
	end

	// only the most negative velocity overflows on negation
	assign vel_neg_sat = (alu_y > SAT_HI) ? SAT_HI[31:0] : alu_y[31:0];

	// config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_mode_q <= MODE_EXIT;
			domain_start_q <= 32'sd0;
			domain_end_q <= 32'sd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE: bc_mode_q <= cfg_wdata[1:0];
				CFG_START: domain_start_q <= cfg_wdata;
				CFG_END: domain_end_q <= cfg_wdata;
				default: bc_mode_q <= bc_mode_q;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			act_q <= 1'b1;
			flip_q <= 1'b0;
			side_q <= 1'b0;
			done_q <= 1'b0;
			refl_cnt_q <= '0;
			div_cnt_q <= '0;
		end else begin
			done_q <= (state_q == ST_FIN);
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						act_q <= 1'b1;
						flip_q <= 1'b0;
						refl_cnt_q <= '0;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					case (bc_mode_q)
						MODE_EXIT: begin
							act_q <= !exit_out;
							state_q <= ST_FIN;
						end
						MODE_WRAP: begin
							if (size_bad || !(below_s || above_e)) begin
								state_q <= ST_FIN;
							end else begin
								side_q <= below_s;
								state_q <= ST_PREP;
							end
						end
						MODE_REFLECT: state_q <= ST_REFL;
						default: state_q <= ST_FIN;
					endcase
				end
				ST_PREP: begin
					div_cnt_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_FIX1;
					end
				end
				ST_FIX1: state_q <= ST_FIX2;
				ST_FIX2: state_q <= ST_FIN;
				ST_REFL: begin
					if (refl_go) begin
						refl_cnt_q <= refl_cnt_q + 1'b1;
						flip_q <= !flip_q;
					end else begin
						act_q <= !(below_s || above_e);
						state_q <= ST_FIN;
					end
				end
				ST_FIN: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					pos_q <= {{(PW-32){item.in_pos[31]}}, item.in_pos};
					vel_q <= item.in_vel;
				end
			end
			ST_CHECK: size_q <= alu_y[31:0];
			ST_PREP: begin
				div_q <= alu_y[31:0];
				rem_q <= '0;
			end
			ST_DIV: begin
				div_q <= {div_q[30:0], 1'b0};
				rem_q <= alu_y[PW-1] ? alu_a[31:0] : alu_y[31:0];
			end
			ST_FIX1: rem_q <= (rem_q == '0) ? '0 : alu_y[31:0];
			ST_FIX2: pos_q <= alu_y;
			ST_REFL: begin
				if (refl_go) begin
					pos_q <= alu_y;
				end
			end
			ST_FIN: begin
				result_q.out_pos <= pos_sat;
				result_q.out_vel <= flip_q ? vel_neg_sat : vel_q;
				result_q.active <= act_q;
			end
			default: pos_q <= pos_q;
		endcase
	end

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted word did not raise busy");

	a_done_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_FIN))
		else $error("done without finish step");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	a_refl_bound: assert property (@(posedge clk) disable iff (!arst_n)
		refl_cnt_q <= CNT_W'(MAX_REFLECT))
		else $error("reflection count past limit");
`endif

endmodule

@@ tb/boundary_checker.sv @@
// Result checker for the particle domain boundary unit: mirrors the register writes,
// predicts each result word from the accepted input word and compares field by field.
// Depends on pdbu_pkg.
module boundary_checker import pdbu_pkg::*; #(
	parameter int MAX_REFLECT = 100
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_wdata,
	input logic start,
	input in_word_t item,
	input logic busy,
	input logic done,
	input out_word_t result,
	output int mismatches,
	output int words_in_flight,
	output int words_checked,
	output int words_inactive
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [1:0] rule;
	logic signed [31:0] lo_bound;
	logic signed [31:0] hi_bound;
	out_word_t predicted_words[$];
	out_word_t want;

	function automatic logic signed [31:0] clamp32(longint x);
		if (x > 64'sd2147483647) return 32'sh7fff_ffff;
		if (x < -64'sd2147483648) return 32'sh8000_0000;
		return x[31:0];
	endfunction

	// boundary rule on 64-bit intermediates, saturated on the way out
	function automatic out_word_t apply_boundary(in_word_t w);
		longint p;
		longint v;
		longint lo;
		longint hi;
		longint span;
		longint k;
		int n;
		bit flip;
		out_word_t r;
		p = $signed(w.in_pos);
		v = $signed(w.in_vel);
		lo = lo_bound;
		hi = hi_bound;
		r.active = 1'b1;
		case (rule)
			MODE_EXIT: begin
				if (p <= lo || p >= hi) r.active = 1'b0;
			end
			MODE_WRAP: begin
				span = hi - lo;
				if (span > 0) begin
					if (p < lo) begin
						k = (lo - p + span - 1) / span;
						p = p + k * span;
					end
					if (p > hi) begin
						k = (p - hi + span - 1) / span;
						p = p - k * span;
					end
				end
			end
			MODE_REFLECT: begin
				n = 0;
				flip = 1'b0;
				// upper bound tested first, also for inverted bounds
				while ((p < lo || p > hi) && n < MAX_REFLECT) begin
					p = (p > hi) ? 2 * hi - p : 2 * lo - p;
					flip = !flip;
					n++;
				end
				if (flip) v = -v;
				if (p < lo || p > hi) r.active = 1'b0;
			end
			default: ;
		endcase
		r.out_pos = clamp32(p);
		r.out_vel = clamp32(v);
		return r;
	endfunction

	// result first, then the new word, then register writes: a word accepted
	// on this edge sees the registers as they were before it
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule = MODE_EXIT;
			lo_bound = 32'sh0000_0000;
			hi_bound = 32'sh0001_0000;
			predicted_words.delete();
			words_in_flight = 0;
		end else begin
			if (done) begin
				if (predicted_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word: pos %0d vel %0d active %b",
							$signed(result.out_pos), $signed(result.out_vel), result.active);
				end else begin
					want = predicted_words.pop_front();
					words_checked++;
					if (result.active === 1'b0) words_inactive++;
					if (result.out_pos !== want.out_pos || result.out_vel !== want.out_vel ||
							result.active !== want.active) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected pos %0d vel %0d active %b, got pos %0d vel %0d active %b",
								$signed(want.out_pos), $signed(want.out_vel), want.active,
								$signed(result.out_pos), $signed(result.out_vel), result.active);
					end
				end
			end
			if (start && !busy) predicted_words.push_back(apply_boundary(item));
			if (cfg_we) begin
				case (cfg_index)
					CFG_MODE: rule = cfg_wdata[1:0];
					CFG_START: lo_bound = cfg_wdata;
					CFG_END: hi_bound = cfg_wdata;
					default: ;
				endcase
			end
			words_in_flight = predicted_words.size();
		end
	end

endmodule

@@ tb/testbench.sv @@
// Top of the boundary unit testbench: clock, reset, register writes and input words.
// Checking lives in boundary_checker; depends on pdbu_pkg and the unit itself.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pdbu_pkg::*;

	localparam int MAX_REFLECT = 100;
	// rule code the unit treats as pass-through, and the unused register slot
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int RANDOM_WORDS = 750;
	// words numbered in this window go out back to back, no sender pauses
	localparam int QUIET_FIRST = 300;
	localparam int QUIET_LAST = 420;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic start;
	in_word_t item;
	logic busy;
	logic done;
	out_word_t result;

	int mismatches;
	int words_in_flight;
	int words_checked;
	int words_inactive;
	int sent;
	int settings;

	particle_domain_boundary_unit #(.MAX_REFLECT(MAX_REFLECT)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.item(item),
		.busy(busy),
		.done(done),
		.result(result)
	);

	boundary_checker #(.MAX_REFLECT(MAX_REFLECT)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.item(item),
		.busy(busy),
		.done(done),
		.result(result),
		.mismatches(mismatches),
		.words_in_flight(words_in_flight),
		.words_checked(words_checked),
		.words_inactive(words_inactive)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// All driving happens on falling edges; the checker samples on rising edges.

	// Offer one word and return on the falling edge after it was taken.
	// busy only moves on a rising edge, so busy low here means the word is
	// accepted at the next rising edge. start may stay high from the last
	// word while busy is high: nothing is taken then.
	task automatic send_word(input logic signed [31:0] pos, input logic signed [31:0] vel);
		while (busy) @(negedge clk);
		start <= 1'b1;
		item <= '{in_pos: pos, in_vel: vel};
		@(negedge clk);
		sent++;
	endtask

	// about 11 pauses in a hundred words, except in the quiet window
	task automatic sender_pause();
		if ((sent < QUIET_FIRST || sent >= QUIET_LAST) && $urandom_range(0, 99) < 11) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	endtask

	task automatic send_paced(input logic signed [31:0] pos, input logic signed [31:0] vel);
		sender_pause();
		send_word(pos, vel);
	endtask

	// Registers may only change with the unit idle: every predicted word back
	// and busy low.
	task automatic drain();
		start <= 1'b0;
		while (words_in_flight != 0 || busy) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	// Rule, both bounds, then junk into the unused slot (must be ignored).
	// Upper bits of the rule word are junk too; only the low two count.
	task automatic set_domain(input logic [1:0] mode, input logic signed [31:0] lo,
			input logic signed [31:0] hi);
		logic [31:0] junk;
		junk = $urandom;
		cfg_we <= 1'b1;
		cfg_index <= CFG_MODE;
		cfg_wdata <= {junk[31:2], mode};
		@(negedge clk);
		cfg_index <= CFG_START;
		cfg_wdata <= lo;
		@(negedge clk);
		cfg_index <= CFG_END;
		cfg_wdata <= hi;
		@(negedge clk);
		cfg_index <= CFG_SPARE;
		cfg_wdata <= $urandom;
		@(negedge clk);
		cfg_we <= 1'b0;
		settings++;
	endtask

	// bounds: mostly within +-8.0, sometimes full range or an extreme
	function automatic logic signed [31:0] pick_bound();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return Q_MIN;
			2: return Q_MAX;
			default: return int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
		endcase
	endfunction

	// positions placed relative to the current bounds: inside, on or right at
	// a bound, up to four spans out, anywhere, or an extreme
	function automatic logic signed [31:0] pick_pos(input logic signed [31:0] lo,
			input logic signed [31:0] hi);
		longint l;
		longint h;
		longint span;
		longint wide;
		longint p;
		longint unsigned r64;
		l = lo;
		h = hi;
		span = h - l;
		wide = (span > 0 ? span : -span) * 4 + 2;
		r64 = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0, 1, 2: p = (span > 0) ? l + longint'(r64 % span) : l;
			3, 4: p = (($urandom & 1) ? h : l) + int'($urandom_range(0, 16)) - 8;
			5, 6: p = ($urandom & 1) ? h + longint'(r64 % wide) : l - longint'(r64 % wide);
			7, 8: p = int'($urandom);
			default: p = ($urandom & 1) ? Q_MAX : Q_MIN;
		endcase
		if (p > longint'(Q_MAX)) p = Q_MAX;
		if (p < longint'(Q_MIN)) p = Q_MIN;
		return p[31:0];
	endfunction

	function automatic logic signed [31:0] pick_vel();
		case ($urandom_range(0, 9))
			0: return Q_MIN;
			1: return Q_MAX;
			2: return 32'sh0;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int r;
		int shape;
		int burst;
		int random_sent;
		int wait_cycles;
		logic [1:0] mode;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] lo;
		logic signed [31:0] hi;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		start = 1'b0;
		item = '0;
		sent = 0;
		settings = 0;
		random_sent = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset values: exit rule on [0, 1.0]. On a bound counts as gone.
		send_paced(32'sh0, 32'sh0);
		send_paced(Q_ONE / 2, Q_MAX);
		send_paced(Q_ONE, Q_MIN);
		send_paced(Q_MIN, 32'sh1);
		send_paced(Q_MAX, -32'sh1);

		// Wrap on [-2.0, 3.0]: far outside both ways, exactly on each bound,
		// one LSB below the lower bound, and one point inside.
		drain();
		set_domain(MODE_WRAP, -2 * Q_ONE, 3 * Q_ONE);
		send_paced(Q_MIN, 32'sh7);
		send_paced(Q_MAX, Q_MIN);
		send_paced(-2 * Q_ONE, 32'sh0);
		send_paced(3 * Q_ONE, 32'sh0);
		send_paced(-2 * Q_ONE - 1, 32'sh5);
		send_paced(Q_ONE, Q_MAX);

		// widest possible domain
		drain();
		set_domain(MODE_WRAP, Q_MIN, Q_MAX);
		send_paced(Q_MIN, 32'sh0);
		send_paced(Q_MAX, 32'sh0);

		// empty domain, then inverted: position passes unchanged
		drain();
		set_domain(MODE_WRAP, Q_ONE, Q_ONE);
		send_paced(32'sh0, 32'sh3);
		drain();
		set_domain(MODE_WRAP, Q_ONE, -Q_ONE);
		send_paced(Q_MAX, Q_MIN);

		// Reflect on [0, 4.0]: one mirror each side, three mirrors, negation of
		// the most negative velocity, and a position too far out for the
		// mirror limit.
		drain();
		set_domain(MODE_REFLECT, 32'sh0, 4 * Q_ONE);
		send_paced(5 * Q_ONE, Q_ONE);
		send_paced(-Q_ONE, Q_MIN);
		send_paced(13 * Q_ONE, -32'sh3);
		send_paced(-32'sh1, Q_MIN);
		send_paced(Q_MAX, 32'sh9);

		// inverted reflect bounds: every mirror moves further out, the
		// position saturates and the particle fails
		drain();
		set_domain(MODE_REFLECT, Q_MAX, Q_MIN);
		send_paced(32'sh0, Q_MIN);

		// unused rule code passes everything through
		drain();
		set_domain(MODE_UNUSED, 32'sh0, Q_ONE);
		send_paced(Q_MIN, Q_MAX);
		send_paced(-5 * Q_ONE, 32'sh3039);

		// Random phases: new rule and bounds, then a burst of words.
		// Mostly ordered bounds, some empty, some inverted.
		while (random_sent < RANDOM_WORDS) begin
			drain();
			r = $urandom_range(0, 99);
			mode = (r < 20) ? MODE_EXIT : (r < 50) ? MODE_WRAP :
				(r < 85) ? MODE_REFLECT : MODE_UNUSED;
			a = pick_bound();
			b = pick_bound();
			lo = (a < b) ? a : b;
			hi = (a < b) ? b : a;
			shape = $urandom_range(0, 99);
			if (shape < 15) begin
				hi = lo;
			end else if (shape < 25) begin
				a = lo;
				lo = hi;
				hi = a;
			end
			set_domain(mode, lo, hi);
			burst = $urandom_range(30, 90);
			repeat (burst) begin
				send_paced(pick_pos(lo, hi), pick_vel());
			end
			random_sent += burst;
		end

		// let the last words come out, bounded
		start <= 1'b0;
		wait_cycles = 0;
		while ((words_in_flight != 0 || busy) && wait_cycles < 5000) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (10) @(negedge clk);

		$display("covered %0d words under %0d register settings; %0d results came back inactive",
			words_checked, settings, words_inactive);
		if (mismatches == 0 && words_in_flight == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// hard stop, several times the slowest legal run
	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end

endmodule

@@ sim.f @@
src/pdbu_pkg.sv
src/pdbu_alu.sv
src/particle_domain_boundary_unit.sv
tb/boundary_checker.sv
tb/testbench.sv
